// ===== rtl/sga_pkg.sv =====
// ---------------------------------------------------------------------------
// sga_pkg
// Shared types, constants and helper functions of the staggered grid average
// block.
// ---------------------------------------------------------------------------
`default_nettype none

package sga_pkg;

  // Grid size and sample storage.
  localparam int MAX_EXTENT_X = 32;
  localparam int MAX_EXTENT_Y = 32;
  localparam int MAX_EXTENT_Z = 32;
  localparam int SAMPLE_WIDTH = 32;

  // Address bits per axis; the grid is laid out as {z, y, x}.
  localparam int AX_W   = (MAX_EXTENT_X > 1) ? $clog2(MAX_EXTENT_X) : 1;
  localparam int AY_W   = (MAX_EXTENT_Y > 1) ? $clog2(MAX_EXTENT_Y) : 1;
  localparam int AZ_W   = (MAX_EXTENT_Z > 1) ? $clog2(MAX_EXTENT_Z) : 1;
  localparam int ADDR_W = AX_W + AY_W + AZ_W;
  localparam int DEPTH  = 2 ** ADDR_W;

  // Up to eight samples are summed, so three guard bits suffice.
  localparam int SUM_W = SAMPLE_WIDTH + 3;

  // Fixed field widths of the stream and configuration ports.
  localparam int COORD_W    = 5;
  localparam int VALUE_W    = 32;
  localparam int EXTENT_W   = 6;
  localparam int SMODE_W    = 4;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTENT_X     = 2'd0,
    REG_EXTENT_Y     = 2'd1,
    REG_EXTENT_Z     = 2'd2,
    REG_STAGGER_MODE = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [EXTENT_W-1:0] extent_x;
    logic [EXTENT_W-1:0] extent_y;
    logic [EXTENT_W-1:0] extent_z;
    logic [SMODE_W-1:0]  stagger_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    DIR_NONE  = 2'd0,
    DIR_PLUS  = 2'd1,
    DIR_MINUS = 2'd2
  } dir_t;

  typedef struct packed {
    dir_t x;
    dir_t y;
    dir_t z;
  } dirs_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_ACC,
    ST_FINISH
  } state_t;

  // Neighbour direction of each axis for a staggering mode. Undefined modes
  // shift nothing, so the query returns the sample at the point itself.
  function automatic dirs_t stagger_dirs(input logic [SMODE_W-1:0] m);
    dirs_t d;
    d = '{x: DIR_NONE, y: DIR_NONE, z: DIR_NONE};
    case (m)
      4'd0:    d.x = DIR_PLUS;
      4'd1:    d.y = DIR_PLUS;
      4'd2:    d.z = DIR_PLUS;
      4'd3:    begin d.x = DIR_PLUS;  d.y = DIR_PLUS;  end
      4'd4:    begin d.x = DIR_PLUS;  d.z = DIR_PLUS;  end
      4'd5:    begin d.y = DIR_PLUS;  d.z = DIR_PLUS;  end
      4'd6:    begin d.x = DIR_PLUS;  d.y = DIR_PLUS;  d.z = DIR_PLUS; end
      4'd7:    begin d.x = DIR_MINUS; d.y = DIR_PLUS;  end
      4'd8:    begin d.x = DIR_MINUS; d.z = DIR_PLUS;  end
      4'd9:    begin d.x = DIR_PLUS;  d.y = DIR_MINUS; end
      4'd10:   begin d.y = DIR_MINUS; d.z = DIR_PLUS;  end
      4'd11:   begin d.x = DIR_PLUS;  d.z = DIR_MINUS; end
      4'd12:   begin d.y = DIR_PLUS;  d.z = DIR_MINUS; end
      default: d = '{x: DIR_NONE, y: DIR_NONE, z: DIR_NONE};
    endcase
    return d;
  endfunction

  // Neighbour along one axis, held at the point on the upper edge and at
  // zero on the lower edge.
  function automatic logic [COORD_W-1:0] neighbour(input logic [COORD_W-1:0] c,
                                                   input logic [EXTENT_W-1:0] ext,
                                                   input dir_t d);
    logic [COORD_W:0] up;
    logic [COORD_W-1:0] r;
    up = {1'b0, c} + 1'b1;
    case (d)
      DIR_PLUS:  r = (up >= ext) ? c : up[COORD_W-1:0];
      DIR_MINUS: r = (c == '0) ? '0 : c - 1'b1;
      default:   r = c;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/staggered_grid_average.sv =====
// ---------------------------------------------------------------------------
// staggered_grid_average
// 3D grid of signed Q16.16 samples with a staggered neighbour-average query.
// ---------------------------------------------------------------------------
// A transfer with tuser 0 stores its sample at the given point; a point
// outside the configured extents is ignored. A transfer with tuser 1
// queries the floor-rounded mean of the 2, 4 or 8 neighbours that
// stagger_mode selects (one sample for an undefined mode) and yields one
// result; a point outside the extents returns zero with the error flag set.
// The grid sits in one memory with a single read port, so a query reads its
// N neighbours one per cycle. The input side is free again as soon as the
// result has moved to the output register. The grid has no reset; query a
// point only after all of its neighbours have been written. Configure only
// while the block is idle.
`default_nettype none

module staggered_grid_average
  import sga_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // coord_x[4:0], coord_y[9:5], coord_z[14:10], sample_value[46:15], zero
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // mode[0]
  input  wire logic [0:0]            s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // average_value[31:0]
  output logic      [OUT_DATA_W-1:0] m_tdata,
  // coord_error[0]
  output logic      [0:0]            m_tuser,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [SAMPLE_WIDTH-1:0] ram_wdata;
  logic [ADDR_W-1:0]       ram_raddr;
  logic [SAMPLE_WIDTH-1:0] ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.extent_x     <= EXTENT_W'(32);
      cfg.extent_y     <= EXTENT_W'(32);
      cfg.extent_z     <= EXTENT_W'(32);
      cfg.stagger_mode <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_EXTENT_X:     cfg.extent_x     <= cfg_data[EXTENT_W-1:0];
        REG_EXTENT_Y:     cfg.extent_y     <= cfg_data[EXTENT_W-1:0];
        REG_EXTENT_Z:     cfg.extent_z     <= cfg_data[EXTENT_W-1:0];
        REG_STAGGER_MODE: cfg.stagger_mode <= cfg_data[SMODE_W-1:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  sga_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sga_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/sga_ram.sv =====
// ---------------------------------------------------------------------------
// sga_ram
// Generic simple dual-port RAM, one write and one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module sga_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/sga_core.sv =====
// ---------------------------------------------------------------------------
// sga_core
// Sequencer of the grid: stores samples, walks the neighbour corners of a
// query through the memory read port, accumulates and holds the result.
// ---------------------------------------------------------------------------
`default_nettype none

module sga_core
  import sga_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire cfg_t                    cfg,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [IN_DATA_W-1:0]    s_tdata,
  input  wire logic [0:0]              s_tuser,
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic      [OUT_DATA_W-1:0]   m_tdata,
  output logic      [0:0]              m_tuser,
  output logic                         ram_we,
  output logic      [ADDR_W-1:0]       ram_waddr,
  output logic      [SAMPLE_WIDTH-1:0] ram_wdata,
  output logic      [ADDR_W-1:0]       ram_raddr,
  input  wire logic [SAMPLE_WIDTH-1:0] ram_rdata
);

  state_t state, state_next;

  logic [EXTENT_W-1:0] ex, ey, ez;
  logic [COORD_W-1:0]  in_x, in_y, in_z;
  logic [VALUE_W-1:0]  in_value;
  logic                in_query, in_range, accept;
  dirs_t               dirs;
  logic [2:0]          in_mask;

  // Query context.
  logic [COORD_W-1:0]  px, py, pz, nx, ny, nz;
  logic [2:0]          mask;
  logic [1:0]          axes;
  logic [2:0]          corner;
  logic                rd_pending;
  logic                err;
  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] mean;

  logic [COORD_W-1:0]  cx, cy, cz;
  logic                out_free;

  assign ex = (int'(cfg.extent_x) > MAX_EXTENT_X) ? EXTENT_W'(MAX_EXTENT_X) : cfg.extent_x;
  assign ey = (int'(cfg.extent_y) > MAX_EXTENT_Y) ? EXTENT_W'(MAX_EXTENT_Y) : cfg.extent_y;
  assign ez = (int'(cfg.extent_z) > MAX_EXTENT_Z) ? EXTENT_W'(MAX_EXTENT_Z) : cfg.extent_z;

  assign in_x     = s_tdata[COORD_W-1:0];
  assign in_y     = s_tdata[2*COORD_W-1:COORD_W];
  assign in_z     = s_tdata[3*COORD_W-1:2*COORD_W];
  assign in_value = s_tdata[3*COORD_W+VALUE_W-1:3*COORD_W];
  assign in_query = s_tuser[0];
  assign in_range = ({1'b0, in_x} < ex) && ({1'b0, in_y} < ey) && ({1'b0, in_z} < ez);
  assign accept   = s_tvalid && s_tready;

  assign dirs    = stagger_dirs(cfg.stagger_mode);
  assign in_mask = {dirs.z != DIR_NONE, dirs.y != DIR_NONE, dirs.x != DIR_NONE};

  assign out_free = !m_tvalid || m_tready;

  // Corner bit k selects the neighbour on axis k.
  assign cx = corner[0] ? nx : px;
  assign cy = corner[1] ? ny : py;
  assign cz = corner[2] ? nz : pz;

  assign mean = acc >>> axes;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && in_query) begin
          state_next = in_range ? ST_READ : ST_FINISH;
        end
      end
      ST_READ: begin
        if (corner == mask) begin
          state_next = ST_ACC;
        end
      end
      ST_ACC: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs. Writes happen only in idle and the reads that a query sums only
  // outside idle, so a summed read never meets a write in the same cycle.
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = {AZ_W'(in_z), AY_W'(in_y), AX_W'(in_x)};
    ram_wdata = SAMPLE_WIDTH'(signed'(in_value));
    ram_raddr = {AZ_W'(cz), AY_W'(cy), AX_W'(cx)};
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        ram_we   = s_tvalid && !in_query && in_range;
      end
      default: begin
        s_tready = 1'b0;
        ram_we   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      rd_pending <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      rd_pending <= (state == ST_READ);
      if (state == ST_FINISH && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && accept && in_query) begin
      px     <= in_x;
      py     <= in_y;
      pz     <= in_z;
      nx     <= neighbour(in_x, ex, dirs.x);
      ny     <= neighbour(in_y, ey, dirs.y);
      nz     <= neighbour(in_z, ez, dirs.z);
      mask   <= in_mask;
      axes   <= 2'($countones(in_mask));
      corner <= '0;
      err    <= !in_range;
      acc    <= '0;
    end else begin
      if (state == ST_READ) begin
        // Step to the next subset of the shifted axes.
        corner <= ((corner | ~mask) + 3'd1) & mask;
      end
      if (rd_pending) begin
        acc <= acc + SUM_W'(signed'(ram_rdata));
      end
    end
    if (state == ST_FINISH && out_free) begin
      m_tdata <= err ? '0 : OUT_DATA_W'(mean);
      m_tuser <= err;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sga_checker.sv =====
// ---------------------------------------------------------------------------
// sga_checker
// Port-level checks of the staggered grid average, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module sga_checker
  import sga_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_tvalid,
  input wire logic                  s_tready,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata,
  input wire logic [0:0]            m_tuser
);

  // A result waiting for its transfer keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // An out-of-range query always reports a zero average.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("error result with non-zero average");

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result pending after reset");

  // No input transfer shows a result in the very next cycle.
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared too early");

endmodule

bind staggered_grid_average sga_checker u_sga_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== verif/staggered_grid_average_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// staggered_grid_average_tb
// Self-checking testbench for the staggered grid average block. A short
// table of directed writes, queries and register writes is followed by
// random phases, each with its own extents and staggering mode. Every query
// result is compared with a value from the table or from a local model.
// ---------------------------------------------------------------------------

module staggered_grid_average_tb;
  import sga_pkg::*;

  localparam logic OP_WRITE     = 1'b0;
  localparam logic OP_QUERY     = 1'b1;
  localparam int   SETTLE_CYCLES = 16;
  localparam int   STALL_LIMIT   = 2000;
  localparam int   RANDOM_ITEMS  = 800;
  localparam int   PHASE_ITEMS   = 60;

  typedef enum logic [SMODE_W-1:0] {
    SM_XP     = 4'd0,
    SM_YP     = 4'd1,
    SM_ZP     = 4'd2,
    SM_XP_YP  = 4'd3,
    SM_XP_ZP  = 4'd4,
    SM_YP_ZP  = 4'd5,
    SM_XP_YP_ZP = 4'd6,
    SM_XM_YP  = 4'd7,
    SM_XM_ZP  = 4'd8,
    SM_XP_YM  = 4'd9,
    SM_YM_ZP  = 4'd10,
    SM_XP_ZM  = 4'd11,
    SM_YP_ZM  = 4'd12,
    SM_UNDEF  = 4'd15
  } stagger_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_QUERY,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_index_t  reg_sel;
    logic [4:0]  x;
    logic [4:0]  y;
    logic [4:0]  z;
    logic [31:0] val;
    bit          typed;
    logic [31:0] avg;
    logic        err;
  } row_t;

  typedef struct {
    logic [31:0] avg;
    logic        err;
  } result_t;

  logic                  clk;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // coord_x[4:0], coord_y[9:5], coord_z[14:10], sample_value[46:15], zero
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  // mode[0]
  logic [0:0]            s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // average_value[31:0]
  logic [OUT_DATA_W-1:0] m_tdata;
  // coord_error[0]
  logic [0:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Local copy of the grid and the registers.
  logic [31:0]           grid_model   [DEPTH];
  bit                    cell_written [DEPTH];
  logic [EXTENT_W-1:0]   ext_x = 6'd32;
  logic [EXTENT_W-1:0]   ext_y = 6'd32;
  logic [EXTENT_W-1:0]   ext_z = 6'd32;
  logic [SMODE_W-1:0]    smode = SM_XP;

  result_t               pending_results [$];
  bit                    steady      = 1'b0;
  int                    items_sent  = 0;
  int                    error_count = 0;
  int                    stall_cycles = 0;

  row_t directed_rows [25] = '{
    '{ROW_WRITE, REG_EXTENT_X, 5'd0,  5'd0,  5'd0,  32'h7FFF_FFFF, 0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_EXTENT_X, 5'd1,  5'd0,  5'd0,  32'h7FFF_FFFF, 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd0,  5'd0,  5'd0,  32'h0, 1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_WRITE, REG_EXTENT_X, 5'd31, 5'd31, 5'd31, 32'h8000_0000, 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd31, 5'd31, 5'd31, 32'h0, 1, 32'h8000_0000, 1'b0},
    '{ROW_WRITE, REG_EXTENT_X, 5'd2,  5'd0,  5'd0,  32'hFFFF_FFFF, 0, 32'h0, 1'b0},
    '{ROW_WRITE, REG_EXTENT_X, 5'd3,  5'd0,  5'd0,  32'h0000_0000, 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd2,  5'd0,  5'd0,  32'h0, 1, 32'hFFFF_FFFF, 1'b0},
    '{ROW_CFG,   REG_STAGGER_MODE, 5'd0, 5'd0, 5'd0, 32'(SM_XP_YP_ZP), 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd31, 5'd31, 5'd31, 32'h0, 1, 32'h8000_0000, 1'b0},
    '{ROW_CFG,   REG_STAGGER_MODE, 5'd0, 5'd0, 5'd0, 32'(SM_XP_YM), 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd0,  5'd0,  5'd0,  32'h0, 1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_CFG,   REG_EXTENT_Z, 5'd0,  5'd0,  5'd0,  32'd0, 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd5,  5'd5,  5'd5,  32'h0, 1, 32'h0, 1'b1},
    '{ROW_WRITE, REG_EXTENT_X, 5'd6,  5'd6,  5'd6,  32'h1234_5678, 0, 32'h0, 1'b0},
    '{ROW_CFG,   REG_EXTENT_Z, 5'd0,  5'd0,  5'd0,  32'd63, 0, 32'h0, 1'b0},
    '{ROW_CFG,   REG_EXTENT_X, 5'd0,  5'd0,  5'd0,  32'd1, 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd1,  5'd0,  5'd0,  32'h0, 1, 32'h0, 1'b1},
    '{ROW_CFG,   REG_STAGGER_MODE, 5'd0, 5'd0, 5'd0, 32'(SM_UNDEF), 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd0,  5'd0,  5'd0,  32'h0, 1, 32'h7FFF_FFFF, 1'b0},
    '{ROW_CFG,   REG_EXTENT_X, 5'd0,  5'd0,  5'd0,  32'd32, 0, 32'h0, 1'b0},
    '{ROW_CFG,   REG_STAGGER_MODE, 5'd0, 5'd0, 5'd0, 32'(SM_XM_YP), 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd20, 5'd17, 5'd9,  32'h0, 0, 32'h0, 1'b0},
    '{ROW_CFG,   REG_EXTENT_Y, 5'd0,  5'd0,  5'd0,  32'd40, 0, 32'h0, 1'b0},
    '{ROW_QUERY, REG_EXTENT_X, 5'd3,  5'd31, 5'd0,  32'h0, 0, 32'h0, 1'b0}
  };

  staggered_grid_average u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int eff_extent(input logic [EXTENT_W-1:0] r, input int maxv);
    return (int'(r) > maxv) ? maxv : int'(r);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_of(input logic [4:0] x, input logic [4:0] y,
                                                input logic [4:0] z);
    return {z, y, x};
  endfunction

  function automatic bit point_inside(input logic [4:0] x, input logic [4:0] y,
                                      input logic [4:0] z);
    return int'(x) < eff_extent(ext_x, MAX_EXTENT_X) &&
           int'(y) < eff_extent(ext_y, MAX_EXTENT_Y) &&
           int'(z) < eff_extent(ext_z, MAX_EXTENT_Z);
  endfunction

  function automatic logic [4:0] step_axis(input logic [4:0] c, input int ext, input dir_t d);
    case (d)
      DIR_PLUS:  return (int'(c) + 1 >= ext) ? c : c + 5'd1;
      DIR_MINUS: return (c == 5'd0) ? 5'd0 : c - 5'd1;
      default:   return c;
    endcase
  endfunction

  // Coordinates of one corner of the averaging box. Bit 0 of the corner
  // picks the shifted x, bit 1 y, bit 2 z; a corner that would need an
  // unshifted axis is not part of the box.
  function automatic bit corner_coords(input logic [4:0] x, input logic [4:0] y,
                                       input logic [4:0] z, input logic [2:0] corner,
                                       output logic [4:0] cx, output logic [4:0] cy,
                                       output logic [4:0] cz);
    dir_t dx;
    dir_t dy;
    dir_t dz;
    dx = DIR_NONE;
    dy = DIR_NONE;
    dz = DIR_NONE;
    case (smode)
      SM_XP:       dx = DIR_PLUS;
      SM_YP:       dy = DIR_PLUS;
      SM_ZP:       dz = DIR_PLUS;
      SM_XP_YP:    begin dx = DIR_PLUS;  dy = DIR_PLUS;  end
      SM_XP_ZP:    begin dx = DIR_PLUS;  dz = DIR_PLUS;  end
      SM_YP_ZP:    begin dy = DIR_PLUS;  dz = DIR_PLUS;  end
      SM_XP_YP_ZP: begin dx = DIR_PLUS;  dy = DIR_PLUS;  dz = DIR_PLUS; end
      SM_XM_YP:    begin dx = DIR_MINUS; dy = DIR_PLUS;  end
      SM_XM_ZP:    begin dx = DIR_MINUS; dz = DIR_PLUS;  end
      SM_XP_YM:    begin dx = DIR_PLUS;  dy = DIR_MINUS; end
      SM_YM_ZP:    begin dy = DIR_MINUS; dz = DIR_PLUS;  end
      SM_XP_ZM:    begin dx = DIR_PLUS;  dz = DIR_MINUS; end
      SM_YP_ZM:    begin dy = DIR_PLUS;  dz = DIR_MINUS; end
      default:     ;
    endcase
    cx = corner[0] ? step_axis(x, eff_extent(ext_x, MAX_EXTENT_X), dx) : x;
    cy = corner[1] ? step_axis(y, eff_extent(ext_y, MAX_EXTENT_Y), dy) : y;
    cz = corner[2] ? step_axis(z, eff_extent(ext_z, MAX_EXTENT_Z), dz) : z;
    return !((corner[0] && dx == DIR_NONE) || (corner[1] && dy == DIR_NONE) ||
             (corner[2] && dz == DIR_NONE));
  endfunction

  function automatic result_t predict_average(input logic [4:0] x, input logic [4:0] y,
                                              input logic [4:0] z);
    result_t    r;
    longint     total;
    longint     mean;
    int         n;
    logic [4:0] cx;
    logic [4:0] cy;
    logic [4:0] cz;
    r.avg = 32'h0;
    r.err = 1'b1;
    if (!point_inside(x, y, z)) return r;
    total = 0;
    n = 0;
    for (int c = 0; c < 8; c++) begin
      if (corner_coords(x, y, z, c[2:0], cx, cy, cz)) begin
        total += longint'($signed(grid_model[cell_of(cx, cy, cz)]));
        n++;
      end
    end
    // The arithmetic shift of the exact sum gives the floor of the mean.
    mean  = total >>> $clog2(n);
    r.avg = mean[31:0];
    r.err = 1'b0;
    return r;
  endfunction

  function automatic logic [31:0] random_sample();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [EXTENT_W-1:0] random_extent();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 6'd0;
    if (r < 12) return 6'($urandom_range(63, 33));
    if (r < 45) return 6'($urandom_range(4, 1));
    return 6'($urandom_range(32, 5));
  endfunction

  function automatic logic [4:0] random_coord(input logic [EXTENT_W-1:0] r, input int maxv,
                                              input bit anywhere);
    int e;
    e = eff_extent(r, maxv);
    if (anywhere || e == 0) return 5'($urandom_range(31));
    return 5'($urandom_range(e - 1));
  endfunction

  task automatic report_error(input string msg);
    if (error_count < 10) $display("%s", msg);
    error_count++;
  endtask

  task automatic send_item(input logic op, input logic [4:0] x, input logic [4:0] y,
                           input logic [4:0] z, input logic [31:0] val, input bit typed,
                           input logic [31:0] t_avg, input logic t_err);
    result_t r;
    @(negedge clk);
    while (!steady && $urandom_range(99) < 8) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {1'b0, val, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == OP_WRITE) begin
      // A write outside the extents leaves the grid alone.
      if (point_inside(x, y, z)) begin
        grid_model[cell_of(x, y, z)]   = val;
        cell_written[cell_of(x, y, z)] = 1'b1;
        items_sent++;
      end
    end else begin
      if (typed) begin
        r.avg = t_avg;
        r.err = t_err;
      end else begin
        r = predict_average(x, y, z);
      end
      pending_results.push_back(r);
      items_sent++;
    end
  endtask

  // The grid has no reset, so every sample a query reads is written first.
  task automatic query_point(input logic [4:0] x, input logic [4:0] y, input logic [4:0] z,
                             input bit typed, input logic [31:0] t_avg, input logic t_err);
    logic [4:0] cx;
    logic [4:0] cy;
    logic [4:0] cz;
    if (point_inside(x, y, z)) begin
      for (int c = 0; c < 8; c++) begin
        if (corner_coords(x, y, z, c[2:0], cx, cy, cz) && !cell_written[cell_of(cx, cy, cz)])
          send_item(OP_WRITE, cx, cy, cz, random_sample(), 1'b0, 32'h0, 1'b0);
      end
    end
    send_item(OP_QUERY, x, y, z, random_sample(), typed, t_avg, t_err);
  endtask

  // Holds the sender off until every result is back and the last write or
  // query has had time to leave the pipeline.
  task automatic settle_block();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_EXTENT_X:     ext_x = data;
      REG_EXTENT_Y:     ext_y = data;
      REG_EXTENT_Z:     ext_z = data;
      REG_STAGGER_MODE: smode = data[SMODE_W-1:0];
      default:          ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    m_tready <= steady || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: average %h error %b", m_tdata, m_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.avg || m_tuser[0] !== want.err)
          report_error($sformatf("mismatch: expected average %h error %b, got %h error %b",
                                 want.avg, want.err, m_tdata, m_tuser));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("staggered_grid_average_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int         target;
    int         phase;
    int         r;
    bit         anywhere;
    logic [4:0] px;
    logic [4:0] py;
    logic [4:0] pz;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      case (directed_rows[i].kind)
        ROW_CFG: begin
          settle_block();
          write_register(directed_rows[i].reg_sel, directed_rows[i].val[CFG_DATA_W-1:0]);
        end
        ROW_WRITE: begin
          send_item(OP_WRITE, directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                    directed_rows[i].val, 1'b0, 32'h0, 1'b0);
        end
        default: begin
          query_point(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                      directed_rows[i].typed, directed_rows[i].avg, directed_rows[i].err);
        end
      endcase
    end

    target = items_sent + RANDOM_ITEMS;
    phase  = 0;
    while (items_sent < target) begin
      settle_block();
      write_register(REG_EXTENT_X, random_extent());
      write_register(REG_EXTENT_Y, random_extent());
      write_register(REG_EXTENT_Z, random_extent());
      if ($urandom_range(99) < 15)
        write_register(REG_STAGGER_MODE, 6'($urandom_range(15, 13)));
      else
        write_register(REG_STAGGER_MODE, 6'($urandom_range(12, 0)));
      steady = (phase == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r        = $urandom_range(99);
        anywhere = (r >= 85) || ($urandom_range(9) == 0);
        px = random_coord(ext_x, MAX_EXTENT_X, anywhere);
        py = random_coord(ext_y, MAX_EXTENT_Y, anywhere);
        pz = random_coord(ext_z, MAX_EXTENT_Z, anywhere);
        if (r < 55 || r >= 85)
          query_point(px, py, pz, 1'b0, 32'h0, 1'b0);
        else
          send_item(OP_WRITE, px, py, pz, random_sample(), 1'b0, 32'h0, 1'b0);
      end
      phase++;
    end
    steady = 1'b0;

    settle_block();
    if (pending_results.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("staggered_grid_average_tb: clean");
    end else begin
      $display("staggered_grid_average_tb: errors");
    end
    $finish;
  end

endmodule
